### sv/lav_pkg.sv
`default_nettype none

package lav_pkg;

  // Field widths are sized for the widest fraction the block supports.
  localparam int FRAC_MAX = 24;
  localparam int QW       = FRAC_MAX + 1;   // unsigned quotient of a normalization
  localparam int UW       = FRAC_MAX + 2;   // signed unit-vector component
  localparam int VW       = UW + 32;        // signed product / vector to normalize
  localparam int MW       = VW + 30;        // scaled magnitude during normalization
  localparam int RW       = VW + 2;         // signed dot-product sum

  // Everything that travels with one item down the pipeline.
  typedef struct packed {
    logic [2:0][31:0]   eye;
    logic [2:0][31:0]   up;
    logic [2:0][VW-1:0] vec;    // vector handed to the normalizer
    logic [2:0][UW-1:0] unit;   // normalizer result
    logic [2:0][UW-1:0] v;      // forward
    logic [2:0][UW-1:0] a;      // side
    logic [2:0][UW-1:0] b;      // true up
    logic [8:0][VW-1:0] prod;   // products and rounded dot sums
    logic [2:0][31:0]   t;      // translation column
    logic               ok;
  } lav_item_t;

endpackage

`default_nettype wire

### sv/lav_norm.sv
`default_nettype none

module lav_norm #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              src_valid,
  output logic                   src_stall,
  input  wire lav_pkg::lav_item_t src_item,
  output logic                   dst_valid,
  input  wire logic              dst_stall,
  output lav_pkg::lav_item_t     dst_item
);

  localparam int QB     = FRAC_BITS + 1;
  localparam int S_ABS  = 0;
  localparam int S_MAX  = 1;
  localparam int S_SH0  = 2;
  localparam int S_SQ   = 8;
  localparam int S_SUM  = 9;
  localparam int S_RT0  = 10;
  localparam int S_DV0  = 42;
  localparam int S_DV1  = 43;
  localparam int S_SGN  = S_DV1 + QB;
  localparam int NS     = S_SGN + 1;

  typedef struct packed {
    logic [2:0][lav_pkg::MW-1:0] mag;
    logic [lav_pkg::MW-1:0]      mx;
    logic [2:0]                  neg;
    logic [2:0][59:0]            sq;
    logic [63:0]                 n;
    logic [63:0]                 r;
    logic [2:0][33:0]            rem;
    logic [2:0][lav_pkg::QW-1:0] q;
    lav_pkg::lav_item_t          item;
  } nw_t;

  function automatic nw_t nstep(input int k, input nw_t x);
    nw_t                     w;
    logic [lav_pkg::VW-1:0]  av;
    logic [lav_pkg::MW-1:0]  big;
    int                      s;
    int                      j;
    logic [63:0]             bitv;
    logic [63:0]             t;
    logic [33:0]             rs;
    logic [33:0]             d;
    logic [lav_pkg::UW-1:0]  qv;
    w = x;
    if (k == S_ABS) begin
      // strip signs, place magnitudes 30 bits up so one right shift scales them
      for (int i = 0; i < 3; i++) begin
        av = w.item.vec[i][lav_pkg::VW-1] ? (~w.item.vec[i] + 1'b1) : w.item.vec[i];
        w.mag[i] = {av, 30'b0};
        w.neg[i] = w.item.vec[i][lav_pkg::VW-1];
      end
      w.item.ok = x.item.ok & (|x.item.vec);
    end else if (k == S_MAX) begin
      big = w.mag[0];
      if (w.mag[1] > big) big = w.mag[1];
      if (w.mag[2] > big) big = w.mag[2];
      w.mx = big;
    end else if (k < S_SQ) begin
      // binary scaling step: keep the largest magnitude at or above 2^29
      s = 32 >> (k - S_SH0);
      if (|(w.mx >> (29 + s))) begin
        w.mx = w.mx >> s;
        for (int i = 0; i < 3; i++) w.mag[i] = w.mag[i] >> s;
      end
    end else if (k == S_SQ) begin
      for (int i = 0; i < 3; i++) w.sq[i] = w.mag[i][29:0] * w.mag[i][29:0];
    end else if (k == S_SUM) begin
      w.n = 64'(w.sq[0]) + 64'(w.sq[1]) + 64'(w.sq[2]);
      w.r = '0;
    end else if (k < S_DV0) begin
      // one digit of the integer square root
      j    = k - S_RT0;
      bitv = 64'd1 << (62 - 2 * j);
      t    = w.r + bitv;
      if (w.n >= t) begin
        w.n = w.n - t;
        w.r = (w.r >> 1) + bitv;
      end else begin
        w.r = w.r >> 1;
      end
    end else if (k == S_DV0) begin
      // numerator is mag * 2^QB + len; its upper part seeds the remainder
      for (int i = 0; i < 3; i++) w.rem[i] = 34'(w.mag[i][29:0]) + 34'(w.r >> QB);
      w.q = '0;
    end else if (k < S_SGN) begin
      // one quotient bit per component; divisor is twice the length
      j = QB - 1 - (k - S_DV1);
      d = {w.r[32:0], 1'b0};
      for (int i = 0; i < 3; i++) begin
        rs = {w.rem[i][32:0], w.r[j]};
        if (rs >= d) begin
          w.rem[i] = rs - d;
          w.q[i]   = {w.q[i][lav_pkg::QW-2:0], 1'b1};
        end else begin
          w.rem[i] = rs;
          w.q[i]   = {w.q[i][lav_pkg::QW-2:0], 1'b0};
        end
      end
    end else begin
      for (int i = 0; i < 3; i++) begin
        qv = lav_pkg::UW'(w.q[i]);
        w.item.unit[i] = w.neg[i] ? (~qv + 1'b1) : qv;
      end
    end
    return w;
  endfunction

  nw_t        st  [NS];
  logic [NS-1:0] val;
  logic [NS-1:0] rdy;

  for (genvar k = 0; k < NS; k++) begin : g_st
    nw_t  pw;
    logic pv;
    logic sr;

    if (k == 0) begin : g_head
      always_comb begin
        pw      = '0;
        pw.item = src_item;
      end
      assign pv = src_valid;
    end else begin : g_body
      assign pw = st[k-1];
      assign pv = val[k-1];
    end

    if (k == NS - 1) begin : g_tail
      assign sr = !dst_stall;
    end else begin : g_mid
      assign sr = rdy[k+1];
    end

    assign rdy[k] = !val[k] || sr;

    always_ff @(posedge clk) begin
      if (rst) begin
        val[k] <= 1'b0;
      end else if (rdy[k]) begin
        val[k] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k] && pv) begin
        st[k] <= nstep(k, pw);
      end
    end
  end

  assign src_stall = !rdy[0];
  assign dst_valid = val[NS-1];
  assign dst_item  = st[NS-1].item;

endmodule

`default_nettype wire

### sv/look_at_view_matrix_unit.sv
`default_nettype none

// Channel  | handshake            | payload
// ---------+----------------------+------------------------------------------
// request  | req_valid, req_stall | eye_*, center_*, up_*  (signed Q.FRAC_BITS)
// column   | col_valid, col_stall | column_index, row0..row3_value,
//          |                      | last_column, degenerate
//
// Every item yields four columns, column 0 first. The pipeline takes a new
// item in any cycle in which its first stage can move; the column serializer
// at the end sends one column a cycle while col_stall is low and loads the
// next matrix as the last column of the current one is taken. Most of the
// pipeline lies in the two normalizers, each a one-digit-per-stage square
// root followed by a one-bit-per-stage divider.
// Reset clears the valid bits and the serializer; payload registers keep
// whatever they hold. A stall on the column side backs up stage by stage; a
// stage that holds no item still fills, so bubbles close up.

module look_at_view_matrix_unit #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               req_valid,
  output logic                    req_stall,
  input  wire logic signed [31:0] eye_x,
  input  wire logic signed [31:0] eye_y,
  input  wire logic signed [31:0] eye_z,
  input  wire logic signed [31:0] center_x,
  input  wire logic signed [31:0] center_y,
  input  wire logic signed [31:0] center_z,
  input  wire logic signed [31:0] up_x,
  input  wire logic signed [31:0] up_y,
  input  wire logic signed [31:0] up_z,
  output logic                    col_valid,
  input  wire logic               col_stall,
  output logic [1:0]              column_index,
  output logic signed [31:0]      row0_value,
  output logic signed [31:0]      row1_value,
  output logic signed [31:0]      row2_value,
  output logic signed [31:0]      row3_value,
  output logic                    last_column,
  output logic                    degenerate
);

  localparam int NT = 8;
  localparam logic [31:0] ONE = 32'd1 << FRAC_BITS;
  localparam logic [lav_pkg::RW-1:0] HALF = lav_pkg::RW'(1) << (FRAC_BITS - 1);

  // Round to nearest, ties away from zero, dropping FRAC_BITS fraction bits.
  function automatic logic signed [lav_pkg::RW-1:0] rshr(
      input logic signed [lav_pkg::RW-1:0] x);
    logic [lav_pkg::RW-1:0] m;
    m = x[lav_pkg::RW-1] ? -x : x;
    m = (m + HALF) >> FRAC_BITS;
    return x[lav_pkg::RW-1] ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic [31:0] sat32(input logic signed [lav_pkg::RW-1:0] x);
    if ((&x[lav_pkg::RW-1:31]) || !(|x[lav_pkg::RW-1:31])) return x[31:0];
    return x[lav_pkg::RW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
  endfunction

  function automatic logic [lav_pkg::VW-1:0] mul_w(input logic [lav_pkg::UW-1:0] a,
                                                   input logic [31:0] b);
    return $signed(a) * $signed(b);
  endfunction

  function automatic logic [lav_pkg::VW-1:0] mul_u(input logic [lav_pkg::UW-1:0] a,
                                                   input logic [lav_pkg::UW-1:0] b);
    return $signed(a) * $signed(b);
  endfunction

  function automatic logic [31:0] sx(input logic [lav_pkg::UW-1:0] u);
    return {{(32 - lav_pkg::UW){u[lav_pkg::UW-1]}}, u};
  endfunction

  // Work of each top-level stage; normalizers sit after stages 0 and 2.
  function automatic lav_pkg::lav_item_t tstep(input int k, input lav_pkg::lav_item_t x);
    lav_pkg::lav_item_t              w;
    logic signed [lav_pkg::RW-1:0]   dd;
    w = x;
    if (k == 1) begin
      // forward vector known: products of V x up
      w.v       = x.unit;
      w.prod[0] = mul_w(x.unit[1], x.up[2]);
      w.prod[1] = mul_w(x.unit[2], x.up[1]);
      w.prod[2] = mul_w(x.unit[2], x.up[0]);
      w.prod[3] = mul_w(x.unit[0], x.up[2]);
      w.prod[4] = mul_w(x.unit[0], x.up[1]);
      w.prod[5] = mul_w(x.unit[1], x.up[0]);
    end else if (k == 2) begin
      for (int i = 0; i < 3; i++) w.vec[i] = x.prod[2*i] - x.prod[2*i+1];
    end else if (k == 3) begin
      // side vector known: products of A x V
      w.a       = x.unit;
      w.prod[0] = mul_u(x.unit[1], x.v[2]);
      w.prod[1] = mul_u(x.unit[2], x.v[1]);
      w.prod[2] = mul_u(x.unit[2], x.v[0]);
      w.prod[3] = mul_u(x.unit[0], x.v[2]);
      w.prod[4] = mul_u(x.unit[0], x.v[1]);
      w.prod[5] = mul_u(x.unit[1], x.v[0]);
    end else if (k == 4) begin
      for (int i = 0; i < 3; i++) begin
        dd     = $signed(x.prod[2*i]) - $signed(x.prod[2*i+1]);
        w.b[i] = lav_pkg::UW'(rshr(dd));
      end
    end else if (k == 5) begin
      for (int i = 0; i < 3; i++) begin
        w.prod[i]     = mul_w(x.a[i], x.eye[i]);
        w.prod[3 + i] = mul_w(x.b[i], x.eye[i]);
        w.prod[6 + i] = mul_w(x.v[i], x.eye[i]);
      end
    end else if (k == 6) begin
      // dot products, rounded back to FRAC_BITS
      for (int r = 0; r < 3; r++) begin
        dd = $signed(x.prod[3*r]);
        dd = dd + $signed(x.prod[3*r+1]) + $signed(x.prod[3*r+2]);
        w.prod[r] = lav_pkg::VW'(rshr(dd));
      end
    end else if (k == 7) begin
      dd = $signed(x.prod[0]);
      w.t[0] = sat32(-dd);
      dd = $signed(x.prod[1]);
      w.t[1] = sat32(-dd);
      dd = $signed(x.prod[2]);
      w.t[2] = sat32(dd);
    end
    return w;
  endfunction

  lav_pkg::lav_item_t tst [NT];
  logic [NT-1:0]      tval;
  logic [NT-1:0]      trdy;

  lav_pkg::lav_item_t n1_item;
  lav_pkg::lav_item_t n2_item;
  logic               n1_valid;
  logic               n1_stall;
  logic               n2_valid;
  logic               n2_stall;
  logic               hold_ready;

  // Stage 0: capture the request and form center - eye.
  lav_pkg::lav_item_t in_item;
  always_comb begin
    logic signed [32:0] dd0;
    logic signed [32:0] dd1;
    logic signed [32:0] dd2;
    in_item        = '0;
    in_item.eye[0] = eye_x;
    in_item.eye[1] = eye_y;
    in_item.eye[2] = eye_z;
    in_item.up[0]  = up_x;
    in_item.up[1]  = up_y;
    in_item.up[2]  = up_z;
    dd0 = {center_x[31], center_x} - {eye_x[31], eye_x};
    dd1 = {center_y[31], center_y} - {eye_y[31], eye_y};
    dd2 = {center_z[31], center_z} - {eye_z[31], eye_z};
    in_item.vec[0] = {{(lav_pkg::VW - 33){dd0[32]}}, dd0};
    in_item.vec[1] = {{(lav_pkg::VW - 33){dd1[32]}}, dd1};
    in_item.vec[2] = {{(lav_pkg::VW - 33){dd2[32]}}, dd2};
    in_item.ok     = 1'b1;
  end

  for (genvar k = 0; k < NT; k++) begin : g_st
    lav_pkg::lav_item_t pw;
    logic               pv;
    logic               sr;

    if (k == 0) begin : g_src
      assign pw = in_item;
      assign pv = req_valid;
    end else if (k == 1) begin : g_n1
      assign pw = n1_item;
      assign pv = n1_valid;
    end else if (k == 3) begin : g_n2
      assign pw = n2_item;
      assign pv = n2_valid;
    end else begin : g_prev
      assign pw = tst[k-1];
      assign pv = tval[k-1];
    end

    if (k == 0) begin : g_to_n1
      assign sr = !n1_stall;
    end else if (k == 2) begin : g_to_n2
      assign sr = !n2_stall;
    end else if (k == NT - 1) begin : g_to_out
      assign sr = hold_ready;
    end else begin : g_next
      assign sr = trdy[k+1];
    end

    assign trdy[k] = !tval[k] || sr;

    always_ff @(posedge clk) begin
      if (rst) begin
        tval[k] <= 1'b0;
      end else if (trdy[k]) begin
        tval[k] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (trdy[k] && pv) begin
        tst[k] <= tstep(k, pw);
      end
    end
  end

  assign req_stall = !trdy[0];

  // Forward vector.
  lav_norm #(.FRAC_BITS(FRAC_BITS)) u_norm_fwd (
    .clk       (clk),
    .rst       (rst),
    .src_valid (tval[0]),
    .src_stall (n1_stall),
    .src_item  (tst[0]),
    .dst_valid (n1_valid),
    .dst_stall (!trdy[1]),
    .dst_item  (n1_item)
  );

  // Side vector.
  lav_norm #(.FRAC_BITS(FRAC_BITS)) u_norm_side (
    .clk       (clk),
    .rst       (rst),
    .src_valid (tval[2]),
    .src_stall (n2_stall),
    .src_item  (tst[2]),
    .dst_valid (n2_valid),
    .dst_stall (!trdy[3]),
    .dst_item  (n2_item)
  );

  // Column serializer: hold one finished matrix, send a column per handshake.
  lav_pkg::lav_item_t hold;
  logic               busy;
  logic [1:0]         cnt;
  logic               col_take;

  assign col_take   = col_valid && !col_stall;
  assign hold_ready = !busy || (col_take && (cnt == 2'd3));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= 2'd0;
    end else begin
      // advance; the counter wraps back to column 0 after the last one
      if (col_take) cnt <= cnt + 2'd1;
      if (hold_ready) busy <= tval[NT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (hold_ready && tval[NT-1]) begin
      hold <= tst[NT-1];
    end
  end

  assign col_valid    = busy;
  assign column_index = cnt;
  assign last_column  = (cnt == 2'd3);
  assign degenerate   = !hold.ok;

  always_comb begin
    logic [31:0] r0;
    logic [31:0] r1;
    logic [31:0] r2;
    logic [31:0] r3;
    unique case (cnt)
      2'd0: begin
        r0 = sx(hold.a[0]);
        r1 = sx(hold.b[0]);
        r2 = sx(~hold.v[0] + 1'b1);
        r3 = '0;
      end
      2'd1: begin
        r0 = sx(hold.a[1]);
        r1 = sx(hold.b[1]);
        r2 = sx(~hold.v[1] + 1'b1);
        r3 = '0;
      end
      2'd2: begin
        r0 = sx(hold.a[2]);
        r1 = sx(hold.b[2]);
        r2 = sx(~hold.v[2] + 1'b1);
        r3 = '0;
      end
      default: begin
        r0 = hold.t[0];
        r1 = hold.t[1];
        r2 = hold.t[2];
        r3 = ONE;
      end
    endcase
    // drop to the identity when a normalization failed
    if (!hold.ok) begin
      r0 = (cnt == 2'd0) ? ONE : '0;
      r1 = (cnt == 2'd1) ? ONE : '0;
      r2 = (cnt == 2'd2) ? ONE : '0;
      r3 = (cnt == 2'd3) ? ONE : '0;
    end
    row0_value = r0;
    row1_value = r1;
    row2_value = r2;
    row3_value = r3;
  end

  // A new matrix always starts at column 0.
  a_restart: assert property (@(posedge clk) disable iff (rst)
    (col_valid && !col_stall && last_column) |=> (!col_valid || column_index == 2'd0))
    else $error("column sequence did not restart at column 0");

  // The bottom row is (0,0,0,1) for a valid matrix.
  a_bottom_row: assert property (@(posedge clk) disable iff (rst)
    (col_valid && !degenerate) |->
      (row3_value == (last_column ? $signed(ONE) : 32'sd0)))
    else $error("bottom row of view matrix is wrong");

  // A degenerate item yields the identity; checked here on column 1.
  a_identity: assert property (@(posedge clk) disable iff (rst)
    (col_valid && degenerate && column_index == 2'd1) |->
      (row0_value == 32'sd0 && row1_value == $signed(ONE) && row2_value == 32'sd0))
    else $error("degenerate item did not produce the identity");

endmodule

`default_nettype wire
